>>> rtl/pp3m4_pkg.sv
package pp3m4_pkg;

  // controller states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CHECK  = 4'b0010,
    ST_DIV    = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  // which trial divisor the running division belongs to
  typedef enum logic [1:0] {
    DIV_BY3  = 2'd0,
    DIV_BYD  = 2'd1,
    DIV_BYD2 = 2'd2
  } div_kind_e;

  localparam int unsigned ResultWidth = 32;
  localparam int unsigned StartWidth  = 32;
  localparam int unsigned OutTdataW   = 40;

endpackage

>>> rtl/prev_prime_3mod4_search_top.sv
// Previous prime congruent to 3 mod 4. For each start value accepted on the slave stream the
// block returns the largest prime strictly below it with value mod 4 == 3, with found = 1;
// a start of three or less returns found = 0 and a zero result. Candidates are walked down
// from start - 1 in steps of four and each one is checked by trial division: by 3, then by
// the pairs d and d + 2 for d = 5, 11, 17, ... while d <= n / d (even numbers never occur).
// All division goes through one radix-2 restoring divider that retires one quotient bit per
// cycle; after the last shift one further step judges the division. The candidate 3 needs
// no division. Any other candidate n needs m divisions: one by 3, two for each divisor pair
// tested in full, and for a prime one more by the first d past the bound, so a prime with
// k pairs (about sqrt(n) / 6) needs m = 2 + 2 * k; a composite stops at the division that
// finds its factor. One start value is worked on at a time; a finished result waits in an
// output register, so the next start value can be taken while the previous result is
// still unread.
module prev_prime_3mod4_search_top #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // tdata: [31:0] start_value
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [pp3m4_pkg::StartWidth-1:0]    s_axis_tdata,
  // tdata: [31:0] prime_result, [32] found, [39:33] zero
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [pp3m4_pkg::OutTdataW-1:0]     m_axis_tdata
);
  import pp3m4_pkg::*;

  localparam int unsigned W    = VALUE_WIDTH;
  localparam int unsigned CntW = $clog2(VALUE_WIDTH);

  localparam logic [W-1:0]    ValOne   = W'(1);
  localparam logic [W-1:0]    ValThree = W'(3);
  localparam logic [W-1:0]    ValFour  = W'(4);
  localparam logic [W-1:0]    ValFive  = W'(5);
  localparam logic [W-1:0]    ValSix   = W'(6);
  localparam logic [W-1:0]    ValTwo   = W'(2);
  localparam logic [CntW-1:0] CntLast  = CntW'(VALUE_WIDTH - 1);

  state_e         state_q, state_d;
  div_kind_e      kind_q, kind_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  // marks the cycle after the last shift, when the division is judged
  logic           eval_q, eval_d;

  // search datapath
  logic [W-1:0] cand_q, cand_d;    // current candidate, also the final result
  logic         found_q, found_d;
  logic [W-1:0] dval_q, dval_d;    // d of the current divisor pair
  logic [W-1:0] dvsr_q, dvsr_d;    // divisor in use
  logic [W-1:0] num_q, num_d;      // dividend shifting out, quotient shifting in
  logic [W-1:0] rem_q, rem_d;      // partial remainder

  // output register
  logic                   out_valid_q, out_valid_d;
  logic [ResultWidth-1:0] out_prime_q, out_prime_d;
  logic                   out_found_q, out_found_d;

  // input conditioning
  logic [W-1:0] start_w;
  logic [W-1:0] cand_init;
  logic         start_low;

  // one restoring division step
  logic [W:0]   rem_sh;
  logic [W:0]   rem_sub;
  logic         div_ge;

  logic         out_load;
  logic         composite;
  logic         prime_hit;

  assign start_w   = W'(s_axis_tdata);
  assign start_low = start_w < ValFour;
  // largest value <= start - 1 with value mod 4 == 3
  assign cand_init = start_w - ValOne - W'(start_w[1:0]);

  assign rem_sh  = {rem_q, num_q[W-1]};
  assign rem_sub = rem_sh - {1'b0, dvsr_q};
  assign div_ge  = rem_sh >= {1'b0, dvsr_q};

  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_load      = (state_q == ST_FINISH) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    cnt_d     = cnt_q;
    eval_d    = 1'b0;
    cand_d    = cand_q;
    found_d   = found_q;
    dval_d    = dval_q;
    dvsr_d    = dvsr_q;
    num_d     = num_q;
    rem_d     = rem_q;
    composite = 1'b0;
    prime_hit = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (start_low) begin
            // no candidate below the start value
            cand_d  = '0;
            found_d = 1'b0;
            state_d = ST_FINISH;
          end else begin
            cand_d  = cand_init;
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (cand_q == ValThree) begin
          found_d = 1'b1;
          state_d = ST_FINISH;
        end else begin
          kind_d  = DIV_BY3;
          dvsr_d  = ValThree;
          num_d   = cand_q;
          rem_d   = '0;
          cnt_d   = CntLast;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (eval_q) begin
          // num_q holds the quotient, rem_q the remainder
          case (kind_q)
            DIV_BY3: begin
              if (rem_q == '0) begin
                composite = 1'b1;
              end else begin
                kind_d = DIV_BYD;
                dval_d = ValFive;
                dvsr_d = ValFive;
              end
            end
            DIV_BYD: begin
              if (num_q < dval_q) begin
                prime_hit = 1'b1;      // d * d > n: no divisor left
              end else if (rem_q == '0) begin
                composite = 1'b1;
              end else begin
                kind_d = DIV_BYD2;
                dvsr_d = dval_q + ValTwo;
              end
            end
            default: begin
              if (rem_q == '0) begin
                composite = 1'b1;
              end else begin
                kind_d = DIV_BYD;
                dval_d = dval_q + ValSix;
                dvsr_d = dval_q + ValSix;
              end
            end
          endcase

          if (prime_hit) begin
            found_d = 1'b1;
            state_d = ST_FINISH;
          end else if (composite) begin
            cand_d  = cand_q - ValFour;
            state_d = ST_CHECK;
          end else begin
            num_d   = cand_q;
            rem_d   = '0;
            cnt_d   = CntLast;
          end
        end else begin
          num_d = {num_q[W-2:0], div_ge};
          rem_d = div_ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
          if (cnt_q == '0) begin
            eval_d = 1'b1;
          end else begin
            cnt_d = cnt_q - CntW'(1);
          end
        end
      end
      default: begin
        // ST_FINISH: wait for room in the output register
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_prime_d = out_prime_q;
    out_found_d = out_found_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      out_prime_d = ResultWidth'(cand_q);
      out_found_d = found_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kind_q      <= DIV_BY3;
      cnt_q       <= '0;
      eval_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      cnt_q       <= cnt_d;
      eval_q      <= eval_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q      <= cand_d;
    found_q     <= found_d;
    dval_q      <= dval_d;
    dvsr_q      <= dvsr_d;
    num_q       <= num_d;
    rem_q       <= rem_d;
    out_prime_q <= out_prime_d;
    out_found_q <= out_found_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutTdataW - ResultWidth - 1)'(0), out_found_q, out_prime_q};

endmodule

>>> bench/prime_search_checker.sv
`timescale 1ns / 100ps

module prime_search_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_valid_i,
  input  logic                               start_ready_i,
  // [31:0] start_value
  input  logic [pp3m4_pkg::StartWidth-1:0]   start_data_i,
  input  logic                               answer_valid_i,
  input  logic                               answer_ready_i,
  // [31:0] prime_result, [32] found, [39:33] zero
  input  logic [pp3m4_pkg::OutTdataW-1:0]    answer_data_i,
  output int                                 mismatches_o,
  output int                                 pending_o,
  output int                                 checked_o,
  output int                                 none_found_o
);

  typedef struct packed {
    logic                                found;
    logic [pp3m4_pkg::ResultWidth-1:0]   value;
  } answer_t;

  answer_t expected_answers[$];

  function automatic bit passes_trial_division(input longint unsigned n);
    longint unsigned d;
    if (n <= 64'd3) return n > 64'd1;
    if ((n % 64'd2) == 64'd0 || (n % 64'd3) == 64'd0) return 1'b0;
    for (d = 64'd5; d <= n / d; d += 64'd6) begin
      if ((n % d) == 64'd0 || (n % (d + 64'd2)) == 64'd0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // walk down through the 3 mod 4 values below start until one is prime
  function automatic answer_t prime_below(input logic [pp3m4_pkg::StartWidth-1:0] start);
    answer_t         ans;
    longint unsigned cand;
    ans = '0;
    if (start >= 4) begin
      cand = {32'd0, start} - 64'd1;
      cand = cand - ((cand + 64'd1) & 64'd3);
      for (; cand >= 64'd3; cand -= 64'd4) begin
        if (passes_trial_division(cand)) begin
          ans.value = cand[pp3m4_pkg::ResultWidth-1:0];
          ans.found = 1'b1;
          break;
        end
      end
    end
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    answer_t want;
    int      bad;
    int      delta;
    if (!rst_ni) begin
      mismatches_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
      none_found_o <= 0;
    end else begin
      bad   = 0;
      delta = 0;
      // retire first: a result can never belong to a start taken at the same edge
      if (answer_valid_i && answer_ready_i) begin
        if (expected_answers.size() == 0) begin
          $error("result with no start value outstanding: tdata %h", answer_data_i);
          bad++;
        end else begin
          want = expected_answers.pop_front();
          delta--;
          if (answer_data_i[31:0] !== want.value) begin
            $error("prime_result: expected %0d, got %0d", want.value, answer_data_i[31:0]);
            bad++;
          end
          if (answer_data_i[32] !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, answer_data_i[32]);
            bad++;
          end
          if (answer_data_i[pp3m4_pkg::OutTdataW-1:33] !== '0) begin
            $error("pad: expected 0, got %h", answer_data_i[pp3m4_pkg::OutTdataW-1:33]);
            bad++;
          end
          checked_o <= checked_o + 1;
          if (!want.found) none_found_o <= none_found_o + 1;
        end
      end
      if (start_valid_i && start_ready_i) begin
        expected_answers.push_back(prime_below(start_data_i));
        delta++;
      end
      mismatches_o <= mismatches_o + bad;
      pending_o    <= pending_o + delta;
    end
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;

  import pp3m4_pkg::*;

  localparam int unsigned MaxIdle      = 16;
  // receiver hold-off; long enough for several small searches to finish
  localparam int unsigned LongHold     = 3000;
  // quiet cycles after the last result
  localparam int unsigned DrainCycles  = 100;
  localparam int unsigned RandomStarts = 75;
  localparam int unsigned NumDirected  = 17;

  logic                  clk_i;
  logic                  rst_ni;

  // start value stream into the block
  logic                  s_tvalid;
  logic                  s_tready;
  logic [StartWidth-1:0] s_tdata;   // [31:0] start_value

  // answer stream out of the block
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OutTdataW-1:0]  m_tdata;   // [31:0] prime_result, [32] found, [39:33] zero

  logic                  tx_no_idle;
  int                    holds_requested;

  int                    mismatches;
  int                    pending;
  int                    checked;
  int                    none_found;
  int                    directed_sent;
  int                    random_sent;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  prev_prime_3mod4_search_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  prime_search_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_valid_i  (s_tvalid),
    .start_ready_i  (s_tready),
    .start_data_i   (s_tdata),
    .answer_valid_i (m_tvalid),
    .answer_ready_i (m_tready),
    .answer_data_i  (m_tdata),
    .mismatches_o   (mismatches),
    .pending_o      (pending),
    .checked_o      (checked),
    .none_found_o   (none_found)
  );

  // offer one start value after a random gap and wait for the transaction;
  // valid stays high afterwards so back-to-back starts never toggle it
  task automatic push_start(input logic [StartWidth-1:0] value);
    int unsigned gap;
    if ($urandom_range(0, 14) == 0) tx_no_idle = !tx_no_idle;
    gap = tx_no_idle ? 0 : $urandom_range(0, MaxIdle);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  // block until every predicted answer has been taken; the counter is
  // registered at the edge, so it is checked only after each edge
  task automatic wait_drained();
    do @(posedge clk_i); while (pending != 0);
  endtask

  // answer sink: random stall before each transaction, long hold on request
  initial begin : answer_sink
    int unsigned stall;
    int          holds_done;
    logic        rx_no_idle;
    rx_no_idle = 1'b0;
    holds_done = 0;
    m_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 19) == 0) rx_no_idle = !rx_no_idle;
      if (holds_requested > holds_done) begin
        // hold-off counted here while the sender keeps offering starts
        stall = LongHold;
        holds_done++;
      end else begin
        stall = rx_no_idle ? 0 : $urandom_range(0, MaxIdle);
      end
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_tvalid) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    logic [StartWidth-1:0] directed_starts [NumDirected];
    logic [StartWidth-1:0] value;
    int unsigned           pick;

    s_tvalid        <= 1'b0;
    s_tdata         <= '0;
    rst_ni          <= 1'b0;
    holds_requested = 0;
    tx_no_idle      = 1'b0;
    directed_sent   = 0;
    random_sent     = 0;

    // starts of three or less have no candidate; four through eight hit 3 and 7;
    // 36, 120 and 144 land first on 35, 119 and 143, products that the divisor
    // pairs must catch right at their bound; the all-ones start tests the top prime
    directed_starts = '{
      32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd8, 32'd12,
      32'd36, 32'd120, 32'd144, 32'd1000, 32'd65536, 32'h000F_FFFF, 32'hFFFF_FFFF
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_starts[i]) begin
      push_start(directed_starts[i]);
      directed_sent++;
    end

    // sender pauses until every outstanding answer is back
    s_tvalid <= 1'b0;
    wait_drained();

    // receiver goes quiet while small starts keep coming: output register and
    // search engine fill and the input side has to stall
    holds_requested++;
    repeat (8) begin
      push_start($urandom_range(4, 300));
      random_sent++;
    end

    // random part: mostly small starts so trial division stays short, a few
    // reaching a million; some below four for the no-result case
    repeat (RandomStarts) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) value = $urandom_range(0, 8);
      else if (pick < 72) value = $urandom_range(0, 4096);
      else if (pick < 96) value = $urandom_range(0, 65535);
      else value = $urandom_range(0, 1 << 20);
      push_start(value);
      random_sent++;
    end

    s_tvalid <= 1'b0;
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("checked %0d answers for %0d directed and %0d random start values",
             checked, directed_sent, random_sent);
    $display("%0d starts had no qualifying prime; largest start was all ones", none_found);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // run limit for the whole simulation
  initial begin : watchdog
    #50_000_000;
    $display("timeout with %0d answers still outstanding", pending);
    $display("status: fail");
    $finish;
  end

endmodule
